[sv/dlle_pkg.sv]
// Package for the doubly linked list engine: field widths, action and status codes,
// and default sizes. No dependencies.
`default_nettype none
package dlle_pkg;

   localparam int DEF_NUM_RECORDS = 256;
   localparam int DEF_NUM_LISTS   = 4;

   localparam int ACT_W    = 4;
   localparam int LIST_W   = 2;
   localparam int REC_W    = 8;
   localparam int CNT_W    = 9;
   localparam int MASK_W   = 4;
   localparam int STAT_W   = 2;
   localparam int WR_SLOTS = 3;

   typedef enum logic [ACT_W-1:0] {
      ACT_CLEAR       = 4'd0,
      ACT_CHAIN       = 4'd1,
      ACT_REMOVE      = 4'd2,
      ACT_REMOVE_ANY  = 4'd3,
      ACT_POP_HEAD    = 4'd4,
      ACT_PUSH_HEAD   = 4'd5,
      ACT_PUSH_TAIL   = 4'd6,
      ACT_BEFORE      = 4'd7,
      ACT_AFTER       = 4'd8,
      ACT_SWAP        = 4'd9,
      ACT_JOIN        = 4'd10
   } action_type;

   typedef enum logic [STAT_W-1:0] {
      ST_OK        = 2'd0,
      ST_EMPTY     = 2'd1,
      ST_NOT_FOUND = 2'd2
   } status_type;

endpackage
`default_nettype wire

[sv/dlle_link_mem.sv]
// One link memory: a single write port and a single read port with registered data.
// Standalone; used twice by the engine top level.
`default_nettype none
module dlle_link_mem #(
   parameter int DEPTH = 256,
   parameter int WIDTH = 9
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

[sv/doubly_linked_list_engine.sv]
// Doubly linked list engine top level: request capture, sequencer, list heads and tails.
// Depends on dlle_pkg and dlle_link_mem (next and prev link memories).
//
//   channel | ports          | direction | beat
//   request | req_valid/ready | in        | action, lists, records, count, candidate mask
//   result  | rsp_valid/ready | out       | popped record, status, head and tail of list_a
//
// A list operation steps through accept, one read of both link memories and three write slots.
// Chaining a block writes one record at a time, set by the single write port per memory.
// Synchronous reset empties every list; link memories are not cleared.
// A new request is taken while a result waits; the last write waits for a free result slot.
`default_nettype none
module doubly_linked_list_engine #(
   parameter int NUM_RECORDS = dlle_pkg::DEF_NUM_RECORDS,
   parameter int NUM_LISTS   = dlle_pkg::DEF_NUM_LISTS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [dlle_pkg::ACT_W-1:0]  req_action,
   input  logic [dlle_pkg::LIST_W-1:0] req_list_a,
   input  logic [dlle_pkg::LIST_W-1:0] req_list_b,
   input  logic [dlle_pkg::REC_W-1:0]  req_record,
   input  logic [dlle_pkg::REC_W-1:0]  req_other_record,
   input  logic [dlle_pkg::CNT_W-1:0]  req_block_count,
   input  logic [dlle_pkg::MASK_W-1:0] req_candidate_mask,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [dlle_pkg::REC_W-1:0]  rsp_popped_record,
   output logic                        rsp_popped_valid,
   output logic [dlle_pkg::STAT_W-1:0] rsp_status,
   output logic [dlle_pkg::REC_W-1:0]  rsp_head_index,
   output logic                        rsp_head_valid,
   output logic [dlle_pkg::REC_W-1:0]  rsp_tail_index,
   output logic                        rsp_tail_valid
);
   import dlle_pkg::*;

   localparam int AW  = $clog2(NUM_RECORDS);
   localparam int LKW = (AW + 1 > REC_W + 1) ? AW + 1 : REC_W + 1;
   localparam int LIW = (NUM_LISTS > 1) ? $clog2(NUM_LISTS) : 1;
   localparam int SW  = $clog2(WR_SLOTS);
   localparam int CW  = $clog2(MASK_W);
   localparam logic [LKW-1:0] NIL = LKW'(NUM_RECORDS);
   localparam logic [SW-1:0] LAST_STEP = SW'(WR_SLOTS - 1);

   typedef logic [LKW-1:0] link_type;

   typedef struct packed {
      logic [WR_SLOTS-1:0]           n_en;
      logic [WR_SLOTS-1:0][LKW-1:0]  n_addr;
      logic [WR_SLOTS-1:0][LKW-1:0]  n_data;
      logic [WR_SLOTS-1:0]           p_en;
      logic [WR_SLOTS-1:0][LKW-1:0]  p_addr;
      logic [WR_SLOTS-1:0][LKW-1:0]  p_data;
      logic                          head_we;
      link_type                      head_val;
      logic                          tail_we;
      link_type                      tail_val;
      logic [LIW-1:0]                list_ix;
   } plan_type;

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_READ  = 4'b0010,
      S_WRITE = 4'b0100,
      S_CHAIN = 4'b1000
   } state_type;

   function automatic logic is_nil(input link_type v);
      return v >= NIL;
   endfunction

   function automatic link_type norm(input link_type v);
      return (v >= NIL) ? NIL : v;
   endfunction

   function automatic plan_type unlink_plan(input logic [LIW-1:0] l, input link_type h,
                                            input link_type t, input link_type r,
                                            input link_type nx, input link_type pv);
      plan_type p;
      link_type pv2;
      p = '0;
      p.list_ix = l;
      pv2 = pv;
      if (h == r) begin
         p.head_we   = 1'b1;
         p.head_val  = norm(nx);
         p.p_en[0]   = !is_nil(nx);
         p.p_addr[0] = nx;
         p.p_data[0] = NIL;
         if (!is_nil(nx) && nx == r) begin
            pv2 = NIL;
         end
      end else begin
         p.n_en[0]   = 1'b1;
         p.n_addr[0] = pv;
         p.n_data[0] = nx;
      end
      if (t == r) begin
         p.tail_we   = 1'b1;
         p.tail_val  = norm(pv2);
         p.n_en[1]   = !is_nil(pv2);
         p.n_addr[1] = pv2;
         p.n_data[1] = NIL;
      end else begin
         p.p_en[1]   = 1'b1;
         p.p_addr[1] = nx;
         p.p_data[1] = pv2;
      end
      return p;
   endfunction

   function automatic plan_type push_head_plan(input logic [LIW-1:0] l, input link_type h,
                                               input link_type t, input link_type r);
      plan_type p;
      p = '0;
      p.list_ix   = l;
      p.n_en[0]   = 1'b1;
      p.n_addr[0] = r;
      p.n_data[0] = h;
      p.p_en[0]   = !is_nil(h);
      p.p_addr[0] = h;
      p.p_data[0] = r;
      p.p_en[1]   = 1'b1;
      p.p_addr[1] = r;
      p.p_data[1] = NIL;
      p.head_we   = 1'b1;
      p.head_val  = r;
      p.tail_we   = is_nil(t);
      p.tail_val  = r;
      return p;
   endfunction

   function automatic plan_type push_tail_plan(input logic [LIW-1:0] l, input link_type h,
                                               input link_type t, input link_type r);
      plan_type p;
      p = '0;
      p.list_ix   = l;
      p.p_en[0]   = 1'b1;
      p.p_addr[0] = r;
      p.p_data[0] = t;
      p.n_en[0]   = !is_nil(t);
      p.n_addr[0] = t;
      p.n_data[0] = r;
      p.n_en[1]   = 1'b1;
      p.n_addr[1] = r;
      p.n_data[1] = NIL;
      p.tail_we   = 1'b1;
      p.tail_val  = r;
      p.head_we   = is_nil(h);
      p.head_val  = r;
      return p;
   endfunction

   state_type state_ff, state_in;
   logic [SW-1:0] step_ff, step_in;

   logic [ACT_W-1:0]  act_ff;
   logic [LIST_W-1:0] la_ff, lb_ff;
   logic [REC_W-1:0]  rec_ff, oth_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic [MASK_W-1:0] mask_ff;

   link_type head_ff [NUM_LISTS];
   link_type tail_ff [NUM_LISTS];
   link_type chain_ptr_ff, chain_last_ff;

   logic              rsp_valid_ff;
   logic [REC_W-1:0]  rsp_pop_rec_ff, rsp_head_ff, rsp_tail_ff;
   logic              rsp_pop_v_ff, rsp_head_v_ff, rsp_tail_v_ff;
   logic [STAT_W-1:0] rsp_stat_ff;

   link_type nx_rd, pv_rd;
   logic n_we, p_we, rd_en;
   logic [AW-1:0] n_wa, p_wa, n_ra, p_ra;
   link_type n_wd, p_wd;

   link_type r_ext, o_ext, ha, ta, hb, tb;
   logic a_ok, b_ok, r_ok, o_ok;
   logic [LIW-1:0] la_ix, lb_ix;

   link_type cand_head [MASK_W];
   link_type cand_tail [MASK_W];
   logic found_hit;
   logic [CW-1:0] found_ix;

   plan_type plan;
   logic [STAT_W-1:0] stat;
   logic [REC_W-1:0] pop_rec;
   logic pop_v;
   link_type no2, avail, ccnt;
   logic chain_go, slot_free, go, fin;
   link_type nh, nt;

   assign r_ext = LKW'(rec_ff);
   assign o_ext = LKW'(oth_ff);
   assign a_ok  = 32'(la_ff) < NUM_LISTS;
   assign b_ok  = 32'(lb_ff) < NUM_LISTS;
   assign r_ok  = r_ext < NIL;
   assign o_ok  = o_ext < NIL;
   assign la_ix = LIW'(la_ff);
   assign lb_ix = LIW'(lb_ff);
   assign ha    = a_ok ? head_ff[la_ix] : NIL;
   assign ta    = a_ok ? tail_ff[la_ix] : NIL;
   assign hb    = b_ok ? head_ff[lb_ix] : NIL;
   assign tb    = b_ok ? tail_ff[lb_ix] : NIL;

   for (genvar g = 0; g < MASK_W; g++) begin : g_cand
      if (g < NUM_LISTS) begin : g_on
         assign cand_head[g] = head_ff[g];
         assign cand_tail[g] = tail_ff[g];
      end else begin : g_off
         assign cand_head[g] = NIL;
         assign cand_tail[g] = NIL;
      end
   end

   always_comb begin
      found_hit = 1'b0;
      found_ix  = '0;
      for (int i = MASK_W - 1; i >= 0; i--) begin
         if (mask_ff[i] && (is_nil(pv_rd) ? (cand_head[i] == r_ext)
                                          : (cand_tail[i] == r_ext))) begin
            found_hit = 1'b1;
            found_ix  = CW'(i);
         end
      end
   end

   always_comb begin
      plan    = '0;
      stat    = ST_OK;
      pop_rec = '0;
      pop_v   = 1'b0;
      no2     = (!is_nil(pv_rd) && pv_rd == o_ext) ? o_ext : nx_rd;
      unique case (act_ff)
         ACT_CLEAR: begin
            if (a_ok) begin
               plan.list_ix  = la_ix;
               plan.head_we  = 1'b1;
               plan.head_val = NIL;
               plan.tail_we  = 1'b1;
               plan.tail_val = NIL;
            end
         end
         ACT_CHAIN: begin
            plan = '0;
         end
         ACT_REMOVE: begin
            if (a_ok && r_ok) begin
               plan = unlink_plan(la_ix, ha, ta, r_ext, nx_rd, pv_rd);
            end
         end
         ACT_REMOVE_ANY: begin
            if (r_ok) begin
               if (!is_nil(nx_rd) && !is_nil(pv_rd)) begin
                  plan.n_en[0]   = 1'b1;
                  plan.n_addr[0] = pv_rd;
                  plan.n_data[0] = nx_rd;
                  plan.p_en[0]   = 1'b1;
                  plan.p_addr[0] = nx_rd;
                  plan.p_data[0] = pv_rd;
               end else if (found_hit) begin
                  plan = unlink_plan(LIW'(found_ix), cand_head[found_ix],
                                     cand_tail[found_ix], r_ext, nx_rd, pv_rd);
               end else begin
                  stat = ST_NOT_FOUND;
               end
            end
         end
         ACT_POP_HEAD: begin
            if (a_ok) begin
               if (is_nil(ha)) begin
                  stat = ST_EMPTY;
               end else begin
                  pop_rec = ha[REC_W-1:0];
                  pop_v   = 1'b1;
                  plan    = unlink_plan(la_ix, ha, ta, ha, nx_rd, pv_rd);
               end
            end
         end
         ACT_PUSH_HEAD: begin
            if (a_ok && r_ok) begin
               plan = push_head_plan(la_ix, ha, ta, r_ext);
            end
         end
         ACT_PUSH_TAIL: begin
            if (a_ok && r_ok) begin
               plan = push_tail_plan(la_ix, ha, ta, r_ext);
            end
         end
         ACT_BEFORE: begin
            if (a_ok && r_ok && o_ok && r_ext != o_ext) begin
               if (ha == o_ext) begin
                  plan = push_head_plan(la_ix, ha, ta, r_ext);
               end else begin
                  plan.n_en[0]   = 1'b1;
                  plan.n_addr[0] = r_ext;
                  plan.n_data[0] = o_ext;
                  plan.n_en[1]   = 1'b1;
                  plan.n_addr[1] = pv_rd;
                  plan.n_data[1] = r_ext;
                  plan.p_en[0]   = 1'b1;
                  plan.p_addr[0] = r_ext;
                  plan.p_data[0] = pv_rd;
                  plan.p_en[1]   = 1'b1;
                  plan.p_addr[1] = o_ext;
                  plan.p_data[1] = r_ext;
               end
            end
         end
         ACT_AFTER: begin
            if (a_ok && r_ok && o_ok && r_ext != o_ext) begin
               if (ta == o_ext) begin
                  plan = push_tail_plan(la_ix, ha, ta, r_ext);
               end else begin
                  plan.n_en[0]   = 1'b1;
                  plan.n_addr[0] = r_ext;
                  plan.n_data[0] = nx_rd;
                  plan.n_en[1]   = 1'b1;
                  plan.n_addr[1] = o_ext;
                  plan.n_data[1] = r_ext;
                  plan.p_en[0]   = 1'b1;
                  plan.p_addr[0] = r_ext;
                  plan.p_data[0] = o_ext;
                  plan.p_en[1]   = 1'b1;
                  plan.p_addr[1] = nx_rd;
                  plan.p_data[1] = r_ext;
               end
            end
         end
         ACT_SWAP: begin
            if (a_ok && r_ok && o_ok && r_ext != o_ext) begin
               plan.list_ix   = la_ix;
               plan.p_en[0]   = 1'b1;
               plan.p_addr[0] = o_ext;
               plan.p_data[0] = pv_rd;
               plan.n_en[0]   = !is_nil(pv_rd);
               plan.n_addr[0] = pv_rd;
               plan.n_data[0] = o_ext;
               plan.head_we   = is_nil(pv_rd);
               plan.head_val  = o_ext;
               plan.n_en[1]   = 1'b1;
               plan.n_addr[1] = r_ext;
               plan.n_data[1] = no2;
               plan.p_en[1]   = !is_nil(no2);
               plan.p_addr[1] = no2;
               plan.p_data[1] = r_ext;
               plan.tail_we   = is_nil(no2);
               plan.tail_val  = r_ext;
               plan.n_en[2]   = 1'b1;
               plan.n_addr[2] = o_ext;
               plan.n_data[2] = r_ext;
               plan.p_en[2]   = 1'b1;
               plan.p_addr[2] = r_ext;
               plan.p_data[2] = o_ext;
            end
         end
         ACT_JOIN: begin
            if (a_ok && b_ok && la_ff != lb_ff && !is_nil(hb)) begin
               plan.list_ix  = la_ix;
               plan.tail_we  = 1'b1;
               plan.tail_val = tb;
               if (is_nil(ha)) begin
                  plan.head_we  = 1'b1;
                  plan.head_val = hb;
               end else begin
                  plan.n_en[0]   = 1'b1;
                  plan.n_addr[0] = ta;
                  plan.n_data[0] = hb;
                  plan.p_en[0]   = 1'b1;
                  plan.p_addr[0] = hb;
                  plan.p_data[0] = ta;
               end
            end
         end
         default: begin
            plan = '0;
         end
      endcase
   end

   assign avail     = NIL - r_ext;
   assign ccnt      = (LKW'(cnt_ff) > avail) ? avail : LKW'(cnt_ff);
   assign chain_go  = (act_ff == ACT_CHAIN) && a_ok && r_ok && (ccnt != '0);
   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      go  = 1'b0;
      fin = 1'b0;
      if (state_ff == S_WRITE) begin
         go  = (step_ff != LAST_STEP) || slot_free;
         fin = slot_free && (step_ff == LAST_STEP);
      end else if (state_ff == S_CHAIN) begin
         go  = (chain_ptr_ff != chain_last_ff) || slot_free;
         fin = slot_free && (chain_ptr_ff == chain_last_ff);
      end
   end

   always_comb begin
      rd_en = (state_ff == S_READ);
      n_ra  = r_ext[AW-1:0];
      p_ra  = r_ext[AW-1:0];
      if (act_ff == ACT_POP_HEAD) begin
         n_ra = ha[AW-1:0];
         p_ra = ha[AW-1:0];
      end else if (act_ff == ACT_AFTER || act_ff == ACT_SWAP) begin
         n_ra = o_ext[AW-1:0];
      end else if (act_ff == ACT_BEFORE) begin
         p_ra = o_ext[AW-1:0];
      end
   end

   always_comb begin
      n_we = 1'b0;
      p_we = 1'b0;
      n_wa = plan.n_addr[step_ff][AW-1:0];
      p_wa = plan.p_addr[step_ff][AW-1:0];
      n_wd = norm(plan.n_data[step_ff]);
      p_wd = norm(plan.p_data[step_ff]);
      if (state_ff == S_WRITE) begin
         n_we = go && plan.n_en[step_ff] && !is_nil(plan.n_addr[step_ff]);
         p_we = go && plan.p_en[step_ff] && !is_nil(plan.p_addr[step_ff]);
      end else if (state_ff == S_CHAIN) begin
         n_we = go;
         p_we = go;
         n_wa = chain_ptr_ff[AW-1:0];
         p_wa = chain_ptr_ff[AW-1:0];
         n_wd = (chain_ptr_ff == chain_last_ff) ? NIL : chain_ptr_ff + LKW'(1);
         p_wd = (chain_ptr_ff == r_ext) ? NIL : chain_ptr_ff - LKW'(1);
      end
   end

   dlle_link_mem #(.DEPTH(NUM_RECORDS), .WIDTH(LKW)) u_next_mem (
      .clock   (clock),
      .wr_en   (n_we),
      .wr_addr (n_wa),
      .wr_data (n_wd),
      .rd_en   (rd_en),
      .rd_addr (n_ra),
      .rd_data (nx_rd)
   );

   dlle_link_mem #(.DEPTH(NUM_RECORDS), .WIDTH(LKW)) u_prev_mem (
      .clock   (clock),
      .wr_en   (p_we),
      .wr_addr (p_wa),
      .wr_data (p_wd),
      .rd_en   (rd_en),
      .rd_addr (p_ra),
      .rd_data (pv_rd)
   );

   always_comb begin
      if (state_ff == S_CHAIN) begin
         nh = r_ext;
         nt = chain_last_ff;
      end else begin
         nh = (plan.head_we && plan.list_ix == la_ix) ? plan.head_val : ha;
         nt = (plan.tail_we && plan.list_ix == la_ix) ? plan.tail_val : ta;
      end
   end

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_READ;
            end
         end
         S_READ: begin
            step_in  = '0;
            state_in = chain_go ? S_CHAIN : S_WRITE;
         end
         S_WRITE: begin
            if (go) begin
               if (step_ff == LAST_STEP) begin
                  state_in = S_IDLE;
               end else begin
                  step_in = step_ff + SW'(1);
               end
            end
         end
         S_CHAIN: begin
            if (fin) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_ready = (state_ff == S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_LISTS; i++) begin
            head_ff[i] <= NIL;
            tail_ff[i] <= NIL;
         end
      end else begin
         state_ff <= state_in;
         step_ff  <= step_in;
         if (fin) begin
            rsp_valid_ff <= 1'b1;
            if (state_ff == S_CHAIN) begin
               head_ff[la_ix] <= r_ext;
               tail_ff[la_ix] <= chain_last_ff;
            end else begin
               if (plan.head_we) begin
                  head_ff[plan.list_ix] <= plan.head_val;
               end
               if (plan.tail_we) begin
                  tail_ff[plan.list_ix] <= plan.tail_val;
               end
            end
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         act_ff  <= req_action;
         la_ff   <= req_list_a;
         lb_ff   <= req_list_b;
         rec_ff  <= req_record;
         oth_ff  <= req_other_record;
         cnt_ff  <= req_block_count;
         mask_ff <= req_candidate_mask;
      end
      if (state_ff == S_READ) begin
         chain_ptr_ff  <= r_ext;
         chain_last_ff <= r_ext + ccnt - LKW'(1);
      end else if (state_ff == S_CHAIN && go && chain_ptr_ff != chain_last_ff) begin
         chain_ptr_ff <= chain_ptr_ff + LKW'(1);
      end
      if (fin) begin
         rsp_pop_rec_ff <= (state_ff == S_CHAIN) ? '0 : pop_rec;
         rsp_pop_v_ff   <= (state_ff == S_CHAIN) ? 1'b0 : pop_v;
         rsp_stat_ff    <= (state_ff == S_CHAIN) ? STAT_W'(ST_OK) : stat;
         if (a_ok && !is_nil(nh) && !is_nil(nt)) begin
            rsp_head_ff   <= nh[REC_W-1:0];
            rsp_tail_ff   <= nt[REC_W-1:0];
            rsp_head_v_ff <= 1'b1;
            rsp_tail_v_ff <= 1'b1;
         end else begin
            rsp_head_ff   <= '0;
            rsp_tail_ff   <= '0;
            rsp_head_v_ff <= 1'b0;
            rsp_tail_v_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_popped_record = rsp_pop_rec_ff;
   assign rsp_popped_valid  = rsp_pop_v_ff;
   assign rsp_status        = rsp_stat_ff;
   assign rsp_head_index    = rsp_head_ff;
   assign rsp_head_valid    = rsp_head_v_ff;
   assign rsp_tail_index    = rsp_tail_ff;
   assign rsp_tail_valid    = rsp_tail_v_ff;

`ifndef SYNTHESIS
   a_accept_reads : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_READ))
      else $error("accepted beat did not start a link read");

   a_idle_no_write : assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE || state_ff == S_READ) |-> (!n_we && !p_we))
      else $error("link memory written outside the write phase");

   a_pop_ok : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_popped_valid) |-> (rsp_status == ST_OK && rsp_head_valid == rsp_tail_valid))
      else $error("popped beat carries an error status");

   a_fin_slot : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_head_index)))
      else $error("result overwritten before it was taken");
`endif

endmodule
`default_nettype wire
